[design/touch_event_generator_defines.svh]
// assertion macros of the checker file of the touch event generator
// depends on nothing; include with the bare file name
`ifndef TOUCH_EVENT_GENERATOR_DEFINES_SVH
`define TOUCH_EVENT_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define TEG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("touch event generator assertion failed");

// next-cycle implication, disabled while reset is low
`define TEG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("touch event generator assertion failed");

// next-cycle implication that is also checked through reset
`define TEG_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("touch event generator assertion failed");

`endif

[design/teg_pkg.sv]
// package of the touch event generator: widths, codes, reset values, states
// depends on nothing
`default_nettype none

package teg_pkg;

    localparam int RAW_BITS    = 12;
    localparam int SIZE_BITS   = 12;
    localparam int THR_BITS    = 12;
    localparam int PERIOD_BITS = 16;
    localparam int POS_BITS    = 16;
    localparam int TIME_BITS   = 32;
    localparam int KIND_BITS   = 2;
    localparam int PROD_BITS   = RAW_BITS + SIZE_BITS;
    localparam int CNT_BITS    = $clog2(SIZE_BITS);

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_V12_BITS  = 12;

    // request fields
    localparam int OFF_NOW      = 0;
    localparam int OFF_PEN      = OFF_NOW + TIME_BITS;
    localparam int OFF_RAW_X    = OFF_PEN + 1;
    localparam int OFF_RAW_Y    = OFF_RAW_X + RAW_BITS;
    localparam int S_TDATA_BITS = ((OFF_RAW_Y + RAW_BITS + 7) / 8) * 8;
    localparam int S_TUSER_BITS = 1;
    localparam int M_TDATA_BITS = 2 * POS_BITS;
    localparam int M_TUSER_BITS = KIND_BITS;

    localparam logic [KIND_BITS-1:0] KIND_DOWN = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_DRAG = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_UP   = 2'd2;

    localparam logic MODE_TICK = 1'b0;
    localparam logic LEVEL_DOWN = 1'b0;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RAW_MIN_X   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAW_MAX_X   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAW_MIN_Y   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAW_MAX_Y   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_W    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_H    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MOVE_THR    = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_MS   = 3'd7;

    localparam logic [RAW_BITS-1:0]    RST_RAW_MIN_X = RAW_BITS'(220);
    localparam logic [RAW_BITS-1:0]    RST_RAW_MAX_X = RAW_BITS'(3780);
    localparam logic [RAW_BITS-1:0]    RST_RAW_MIN_Y = RAW_BITS'(340);
    localparam logic [RAW_BITS-1:0]    RST_RAW_MAX_Y = RAW_BITS'(3850);
    localparam logic [SIZE_BITS-1:0]   RST_SCREEN_W  = 12'd320;
    localparam logic [SIZE_BITS-1:0]   RST_SCREEN_H  = 12'd240;
    localparam logic [THR_BITS-1:0]    RST_MOVE_THR  = 12'd20;
    localparam logic [PERIOD_BITS-1:0] RST_REPEAT_MS = 16'd2;
    localparam logic [TIME_BITS-1:0]   RST_LAST_CHG  = 32'h8000_0000;
    localparam logic [POS_BITS-1:0]    NO_POS        = 16'd64000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_CMP,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

[design/touch_event_generator.sv]
// sequence: a pen up request passes the evaluate and output states after acceptance;
// a sample passes the evaluate state, per axis a setup state plus 12 steps of the shared
// restoring divider (skipped at or past the span ends), then compare, output if moved.
// one request at a time: a new request is taken only in the idle state
// reset: synchronous active low; registers return to defaults, pen up, no position
// depends on teg_pkg
`default_nettype none

module touch_event_generator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // config write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [teg_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [teg_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // request stream
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // now_ms, pen_level, raw_x, raw_y, zero fill
    input  wire logic [teg_pkg::S_TDATA_BITS-1:0]    i_s_axis_tdata,
    // mode
    input  wire logic [teg_pkg::S_TUSER_BITS-1:0]    i_s_axis_tuser,
    // event stream
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // pos_x, pos_y
    output logic [teg_pkg::M_TDATA_BITS-1:0]         o_m_axis_tdata,
    // event_kind
    output logic [teg_pkg::M_TUSER_BITS-1:0]         o_m_axis_tuser
);

    localparam int RB = teg_pkg::RAW_BITS;
    localparam int SB = teg_pkg::SIZE_BITS;
    localparam int PB = teg_pkg::POS_BITS;
    localparam int TB = teg_pkg::TIME_BITS;

    // config registers
    logic [RB-1:0]                     r_min_x, r_max_x, r_min_y, r_max_y;
    logic [SB-1:0]                     r_width, r_height;
    logic [teg_pkg::THR_BITS-1:0]      r_thr;
    logic [teg_pkg::PERIOD_BITS-1:0]   r_period;
    logic [teg_pkg::CFG_V12_BITS-1:0]  cfg_v12;

    // control and state
    teg_pkg::t_state                   r_state, n_state;
    logic                              r_pen_down, n_pen_down;
    logic                              r_await, n_await;
    logic [PB-1:0]                     r_last_x, n_last_x, r_last_y, n_last_y;
    logic [TB-1:0]                     r_last_chg, n_last_chg;
    logic                              r_out_valid, n_out_valid;

    // request latch and datapath
    logic                              r_mode;
    logic [TB-1:0]                     r_now;
    logic                              r_level;
    logic [RB-1:0]                     r_raw_x, r_raw_y;
    logic                              r_axis, n_axis;
    logic [RB-1:0]                     r_rem, n_rem;
    logic [RB-1:0]                     r_den, n_den;
    logic [SB-1:0]                     r_quo, n_quo;
    logic [teg_pkg::CNT_BITS-1:0]      r_cnt, n_cnt;
    logic [SB-1:0]                     r_res_x, n_res_x, r_res_y, n_res_y;
    logic [teg_pkg::KIND_BITS-1:0]     r_kind, n_kind;
    logic [PB-1:0]                     r_out_x, n_out_x, r_out_y, n_out_y;
    logic [teg_pkg::KIND_BITS-1:0]     r_out_kind, n_out_kind;

    // shared decisions
    logic                              in_fire;
    logic                              too_soon;
    logic                              start_sample;
    logic                              pen_up;
    logic [RB-1:0]                     sel_raw, sel_lo, sel_hi;
    logic [SB-1:0]                     sel_size;
    logic                              at_low, saturate;
    logic [teg_pkg::PROD_BITS-1:0]     prod;
    logic [RB:0]                       trial, trial_sub;
    logic                              trial_ge;
    logic                              div_last;
    logic [SB-1:0]                     quo_step;
    logic [PB-1:0]                     x_ext, y_ext, dx, dy;
    logic                              moved;
    logic                              out_free;
    logic                              axis_done;
    logic [SB-1:0]                     axis_res;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == teg_pkg::S_IDLE);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_v12         = i_cfg_data[teg_pkg::CFG_V12_BITS-1:0];

    assign too_soon     = (r_now - r_last_chg) < TB'(r_period);
    assign start_sample = (r_mode == teg_pkg::MODE_TICK) ? r_pen_down
                        : (!too_soon && r_level == teg_pkg::LEVEL_DOWN);
    assign pen_up       = (r_mode != teg_pkg::MODE_TICK) && !too_soon
                        && (r_level != teg_pkg::LEVEL_DOWN);

    assign sel_raw  = r_axis ? r_raw_y  : r_raw_x;
    assign sel_lo   = r_axis ? r_min_y  : r_min_x;
    assign sel_hi   = r_axis ? r_max_y  : r_max_x;
    assign sel_size = r_axis ? r_height : r_width;

    // at or past the top of the span the quotient is at least the size
    assign at_low   = (sel_raw <= sel_lo);
    assign saturate = (sel_hi <= sel_lo) || (sel_raw >= sel_hi);
    assign prod     = teg_pkg::PROD_BITS'(sel_raw - sel_lo)
                    * teg_pkg::PROD_BITS'(sel_size);

    // one restoring divide step
    assign trial     = {r_rem, r_quo[SB-1]};
    assign trial_ge  = (trial >= {1'b0, r_den});
    assign trial_sub = trial - {1'b0, r_den};
    assign quo_step  = {r_quo[SB-2:0], trial_ge};
    assign div_last  = (r_cnt == teg_pkg::CNT_BITS'(SB - 1));

    assign axis_done = ((r_state == teg_pkg::S_MUL) && (at_low || saturate))
                    || ((r_state == teg_pkg::S_DIV) && div_last);
    assign axis_res  = (r_state == teg_pkg::S_DIV) ? quo_step
                     : (at_low ? '0 : sel_size);

    assign x_ext = PB'(r_res_x);
    assign y_ext = PB'(r_res_y);
    assign dx    = (x_ext > r_last_x) ? (x_ext - r_last_x) : (r_last_x - x_ext);
    assign dy    = (y_ext > r_last_y) ? (y_ext - r_last_y) : (r_last_y - y_ext);
    assign moved = (dx > PB'(r_thr)) || (dy > PB'(r_thr));

    assign out_free = !r_out_valid || i_m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            teg_pkg::S_IDLE: begin
                if (in_fire) n_state = teg_pkg::S_EVAL;
            end
            teg_pkg::S_EVAL: begin
                if (start_sample)  n_state = teg_pkg::S_MUL;
                else if (pen_up)   n_state = teg_pkg::S_OUT;
                else               n_state = teg_pkg::S_IDLE;
            end
            teg_pkg::S_MUL: begin
                if (!(at_low || saturate)) n_state = teg_pkg::S_DIV;
                else if (r_axis)           n_state = teg_pkg::S_CMP;
            end
            teg_pkg::S_DIV: begin
                if (div_last) n_state = r_axis ? teg_pkg::S_CMP : teg_pkg::S_MUL;
            end
            teg_pkg::S_CMP: begin
                n_state = moved ? teg_pkg::S_OUT : teg_pkg::S_IDLE;
            end
            teg_pkg::S_OUT: begin
                if (out_free) n_state = teg_pkg::S_IDLE;
            end
            default: n_state = teg_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_pen_down  = r_pen_down;
        n_await     = r_await;
        n_last_x    = r_last_x;
        n_last_y    = r_last_y;
        n_last_chg  = r_last_chg;
        n_axis      = r_axis;
        n_rem       = r_rem;
        n_den       = r_den;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_res_x     = r_res_x;
        n_res_y     = r_res_y;
        n_kind      = r_kind;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_kind  = r_out_kind;
        case (r_state)
            teg_pkg::S_EVAL: begin
                n_axis = 1'b0;
                if (r_mode != teg_pkg::MODE_TICK && !too_soon) begin
                    n_last_chg = r_now;
                    n_pen_down = (r_level == teg_pkg::LEVEL_DOWN);
                    if (pen_up) begin
                        n_await = 1'b1;
                        n_kind  = teg_pkg::KIND_UP;
                    end
                end
            end
            teg_pkg::S_MUL: begin
                n_rem = prod[teg_pkg::PROD_BITS-1:SB];
                n_quo = prod[SB-1:0];
                n_den = sel_hi - sel_lo;
                n_cnt = '0;
            end
            teg_pkg::S_DIV: begin
                n_rem = trial_ge ? trial_sub[RB-1:0] : trial[RB-1:0];
                n_quo = quo_step;
                n_cnt = r_cnt + 1'b1;
            end
            teg_pkg::S_CMP: begin
                if (moved) begin
                    n_last_x = x_ext;
                    n_last_y = y_ext;
                    n_kind   = r_await ? teg_pkg::KIND_DOWN : teg_pkg::KIND_DRAG;
                    n_await  = 1'b0;
                end
            end
            teg_pkg::S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_last_x;
                    n_out_y     = r_last_y;
                    n_out_kind  = r_kind;
                end
            end
            default: begin
            end
        endcase
        if (axis_done) begin
            if (r_axis) n_res_y = axis_res;
            else        n_res_x = axis_res;
            n_axis = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= teg_pkg::S_IDLE;
            r_pen_down  <= 1'b0;
            r_await     <= 1'b1;
            r_last_x    <= teg_pkg::NO_POS;
            r_last_y    <= teg_pkg::NO_POS;
            r_last_chg  <= teg_pkg::RST_LAST_CHG;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pen_down  <= n_pen_down;
            r_await     <= n_await;
            r_last_x    <= n_last_x;
            r_last_y    <= n_last_y;
            r_last_chg  <= n_last_chg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x  <= teg_pkg::RST_RAW_MIN_X;
            r_max_x  <= teg_pkg::RST_RAW_MAX_X;
            r_min_y  <= teg_pkg::RST_RAW_MIN_Y;
            r_max_y  <= teg_pkg::RST_RAW_MAX_Y;
            r_width  <= teg_pkg::RST_SCREEN_W;
            r_height <= teg_pkg::RST_SCREEN_H;
            r_thr    <= teg_pkg::RST_MOVE_THR;
            r_period <= teg_pkg::RST_REPEAT_MS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                teg_pkg::CFG_RAW_MIN_X: r_min_x  <= RB'(cfg_v12);
                teg_pkg::CFG_RAW_MAX_X: r_max_x  <= RB'(cfg_v12);
                teg_pkg::CFG_RAW_MIN_Y: r_min_y  <= RB'(cfg_v12);
                teg_pkg::CFG_RAW_MAX_Y: r_max_y  <= RB'(cfg_v12);
                teg_pkg::CFG_SCREEN_W:  r_width  <= SB'(cfg_v12);
                teg_pkg::CFG_SCREEN_H:  r_height <= SB'(cfg_v12);
                teg_pkg::CFG_MOVE_THR:  r_thr    <= teg_pkg::THR_BITS'(cfg_v12);
                teg_pkg::CFG_REPEAT_MS: r_period <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode  <= i_s_axis_tuser[0];
            r_now   <= i_s_axis_tdata[teg_pkg::OFF_NOW +: TB];
            r_level <= i_s_axis_tdata[teg_pkg::OFF_PEN];
            r_raw_x <= i_s_axis_tdata[teg_pkg::OFF_RAW_X +: RB];
            r_raw_y <= i_s_axis_tdata[teg_pkg::OFF_RAW_Y +: RB];
        end
        r_axis     <= n_axis;
        r_rem      <= n_rem;
        r_den      <= n_den;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_res_x    <= n_res_x;
        r_res_y    <= n_res_y;
        r_kind     <= n_kind;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_kind <= n_out_kind;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_y, r_out_x};
    assign o_m_axis_tuser  = r_out_kind;

endmodule

`default_nettype wire

[design/teg_checker.sv]
// port-level checker of the touch event generator, bound to the top level
// depends on teg_pkg and touch_event_generator_defines.svh
`default_nettype none
`include "touch_event_generator_defines.svh"

module teg_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_s_axis_tvalid,
    input wire logic                                o_s_axis_tready,
    input wire logic                                o_m_axis_tvalid,
    input wire logic                                i_m_axis_tready,
    input wire logic [teg_pkg::M_TDATA_BITS-1:0]    o_m_axis_tdata,
    input wire logic [teg_pkg::M_TUSER_BITS-1:0]    o_m_axis_tuser
);

    // a stalled event holds
    `TEG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // only down, drag or up leave the block
    `TEG_ASSERT_IMPL(a_kind_code, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tuser == teg_pkg::KIND_DOWN || o_m_axis_tuser == teg_pkg::KIND_DRAG || o_m_axis_tuser == teg_pkg::KIND_UP)

    // not ready in the cycle after taking a request
    `TEG_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

    // reset empties the output register and leaves the block ready
    `TEG_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_m_axis_tvalid && o_s_axis_tready)

endmodule

bind touch_event_generator teg_checker u_teg_checker (.*);

`default_nettype wire
